// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ope_pkg.sv -----
// ----------------------------------------------------------------------------
// ope_pkg
// Types, sizes and codes shared by the onion preserving edge swap engine.
// ----------------------------------------------------------------------------
package ope_pkg;

    localparam int NODES   = 256;
    localparam int EDGES   = 1024;
    localparam int NODE_W  = $clog2(NODES);
    localparam int EDGE_W  = $clog2(EDGES);
    localparam int CORE_W  = 8;
    localparam int LAYER_W = 9;
    localparam int CNT_W   = 9;
    localparam int CORE_SLOTS = 256;

    typedef enum logic [1:0] {
        FN_NODE = 2'd0,
        FN_EDGE = 2'd1,
        FN_SWAP = 2'd2,
        FN_NOP  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_SELF_LOOP = 3'd1,
        STAT_EXISTS    = 3'd2,
        STAT_ONION     = 3'd3,
        STAT_SAME      = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE_WR,
        ST_NODE_MIN,
        ST_EDGE_RD,
        ST_EDGE_CAP,
        ST_EDGE_CNT,
        ST_EDGE_WA,
        ST_EDGE_RB,
        ST_EDGE_WB,
        ST_SW_RD1,
        ST_SW_RD2,
        ST_SW_PAIR,
        ST_SW_SEL,
        ST_SW_ADJ1,
        ST_SW_ADJ2,
        ST_SW_NRD,
        ST_SW_NCAP,
        ST_SW_MCAP,
        ST_SW_CHECK,
        ST_SW_URD,
        ST_SW_UWR,
        ST_SW_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] b;
        logic [NODE_W-1:0] a;
    } edge_t;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [CORE_W-1:0]  core;
    } node_rec_t;

    typedef struct packed {
        logic [CNT_W-1:0] rd;
        logic [CNT_W-1:0] br;
    } cnt_rec_t;

    typedef struct packed {
        logic                edge_we;
        logic [EDGE_W-1:0]   edge_addr;
        edge_t               edge_wdata;
        logic                adj_clr;
        logic                adj_we;
        logic [NODE_W-1:0]   adj_row;
        logic [NODE_W-1:0]   adj_col;
        logic                adj_bit;
        logic                node_we;
        logic [NODE_W-1:0]   node_addr;
        node_rec_t           node_wdata;
        logic                cnt_we;
        logic [NODE_W-1:0]   cnt_addr;
        cnt_rec_t            cnt_wdata;
        logic                minl_we;
        logic [CORE_W-1:0]   minl_addr;
        logic [LAYER_W-1:0]  minl_wdata;
    } mem_req_t;

    typedef struct packed {
        edge_t              edge_rdata;
        logic               adj_bit;
        node_rec_t          node_rdata;
        cnt_rec_t           cnt_rdata;
        logic [LAYER_W-1:0] minl_rdata;
    } mem_rsp_t;

    typedef struct packed {
        logic               mode_cnt;
        logic [LAYER_W-1:0] l;
        logic [LAYER_W-1:0] lc;
        logic [LAYER_W-1:0] ln;
        logic [CORE_W-1:0]  core;
        logic [CNT_W-1:0]   br;
        logic [CNT_W-1:0]   rd;
        logic               min_match;
    } onion_in_t;

    typedef struct packed {
        logic             changed;
        logic [CNT_W-1:0] br_next;
        logic [CNT_W-1:0] rd_next;
    } onion_out_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic               cross_req;
        logic [EDGE_W-1:0]  second_edge_index;
        logic [NODE_W-1:0]  end_b;
        logic [NODE_W-1:0]  end_a;
        logic [EDGE_W-1:0]  edge_index;
        logic [LAYER_W-1:0] layer;
        logic [CORE_W-1:0]  core;
        logic [NODE_W-1:0]  node;
    } in_item_t;

    typedef struct packed {
        logic [4:0]        pad;
        logic [NODE_W-1:0] new_second_b;
        logic [NODE_W-1:0] new_second_a;
        logic [NODE_W-1:0] new_first_b;
        logic [NODE_W-1:0] new_first_a;
        status_t           status;
    } out_item_t;

endpackage

// ----- hw/rtl/ope_store.sv -----
// ----------------------------------------------------------------------------
// ope_store
// Single-port graph stores: edges, adjacency rows, node records, neighbour
// counts and minimum layer per core. Read data is registered, read-first.
// ----------------------------------------------------------------------------
module ope_store
    import ope_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    edge_t              edge_mem [EDGES];
    logic [NODES-1:0]   adj_mem  [NODES];
    node_rec_t          node_mem [NODES];
    cnt_rec_t           cnt_mem  [NODES];
    logic [LAYER_W-1:0] minl_mem [CORE_SLOTS];

    logic [NODES-1:0]  adj_row_reg;
    logic [NODE_W-1:0] adj_col_reg;

    always_ff @(posedge clk)
    begin
        if (req.edge_we)
        begin
            edge_mem[req.edge_addr] <= req.edge_wdata;
        end
        rsp.edge_rdata <= edge_mem[req.edge_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.adj_clr)
        begin
            adj_mem[req.adj_row] <= '0;
        end
        else if (req.adj_we)
        begin
            adj_mem[req.adj_row][req.adj_col] <= req.adj_bit;
        end
        adj_row_reg <= adj_mem[req.adj_row];
        adj_col_reg <= req.adj_col;
    end

    assign rsp.adj_bit = adj_row_reg[adj_col_reg];

    always_ff @(posedge clk)
    begin
        if (req.node_we)
        begin
            node_mem[req.node_addr] <= req.node_wdata;
        end
        rsp.node_rdata <= node_mem[req.node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.cnt_we)
        begin
            cnt_mem[req.cnt_addr] <= req.cnt_wdata;
        end
        rsp.cnt_rdata <= cnt_mem[req.cnt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.minl_we)
        begin
            minl_mem[req.minl_addr] <= req.minl_wdata;
        end
        rsp.minl_rdata <= minl_mem[req.minl_addr];
    end

endmodule

// ----- hw/rtl/ope_onion_unit.sv -----
// ----------------------------------------------------------------------------
// ope_onion_unit
// Shared layer compare unit: onion change test, count adjustment on a
// neighbour swap, and neighbour counting on an edge load, for one node.
// ----------------------------------------------------------------------------
module ope_onion_unit
    import ope_pkg::*;
(
    input  onion_in_t  req,
    output onion_out_t rsp
);

    logic signed [LAYER_W+1:0] ls;
    logic signed [LAYER_W+1:0] lm1;
    logic signed [LAYER_W+1:0] lcs;
    logic signed [LAYER_W+1:0] lns;
    logic br_full;
    logic rd_full;
    logic inc_br;
    logic dec_br;
    logic inc_rd;
    logic dec_rd;

    always_comb
    begin
        ls  = signed'({2'b00, req.l});
        lm1 = ls - 11'sd1;
        lcs = signed'({2'b00, req.lc});
        lns = signed'({2'b00, req.ln});
        br_full = (req.br == ({1'b0, req.core} + 9'd1));
        rd_full = (req.rd == {1'b0, req.core});

        // onion layer test when neighbour lc is replaced by ln
        priority if (req.min_match)
            rsp.changed = (lns < ls);
        else if (lcs >= ls)
            rsp.changed = br_full && (lns < lm1);
        else if (lcs == lm1)
            rsp.changed = br_full ? (lns < lm1) : (rd_full && (lns >= ls));
        else
            rsp.changed = rd_full && (lns >= ls);

        inc_br = 1'b0;
        dec_br = 1'b0;
        inc_rd = 1'b0;
        dec_rd = 1'b0;
        if (req.mode_cnt)
        begin
            inc_rd = (lns >= ls);
            inc_br = (lns >= lm1);
        end
        else
        begin
            priority if (lcs >= ls)
            begin
                if (lns == lm1)
                begin
                    dec_rd = 1'b1;
                end
                else if (lns < lm1)
                begin
                    dec_br = 1'b1;
                    dec_rd = 1'b1;
                end
            end
            else if (lcs == lm1)
            begin
                if (lns >= ls)
                begin
                    inc_rd = 1'b1;
                end
                else if (lns < lm1)
                begin
                    dec_br = 1'b1;
                end
            end
            else
            begin
                if (lns >= ls)
                begin
                    inc_br = 1'b1;
                    inc_rd = 1'b1;
                end
                else if (lns == lm1)
                begin
                    inc_br = 1'b1;
                end
            end
        end

        rsp.br_next = inc_br ? req.br + 9'd1 : (dec_br ? req.br - 9'd1 : req.br);
        rsp.rd_next = inc_rd ? req.rd + 9'd1 : (dec_rd ? req.rd - 9'd1 : req.rd);
    end

endmodule

// ----- hw/rtl/onion_preserving_edge_swap_top.sv -----
// ----------------------------------------------------------------------------
// onion_preserving_edge_swap_top
// Edge swap engine that keeps every node's k-core and onion layer.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries the function (load node, load edge,
// propose swap, no operation), tdata the item fields. Output stream m_axis
// returns one status transaction per input transaction.
// Load all nodes first, then all edges, then send swap proposals.
// After reset a clearing pass zeroes adjacency rows and counts and sets every
// minimum layer to all ones; s_axis_tready stays low.
// One item at a time, each store having a single port; a rejected swap
// returns its status on m_axis without writing any store.
// The four node records of a swap are read and tested one after another
// through one shared compare unit, then the neighbour counts are updated
// and the adjacency bits are rewritten one per cycle.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onion_preserving_edge_swap_top
    import ope_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node[7:0] core[15:8] layer[24:16] edge_index[34:25] end_a[42:35]
    // end_b[50:43] second_edge_index[60:51] cross_req[61] zero[63:62]
    input  logic [63:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0] new_first_a[10:3] new_first_b[18:11] new_second_a[26:19]
    // new_second_b[34:27] zero[39:35]
    output logic [39:0] m_axis_tdata
);

    state_t            state_reg, state_next;
    logic [2:0]        k_reg, k_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    in_item_t           item_reg;
    func_t              func_reg;
    status_t            status_reg;
    out_item_t          out_reg;
    logic               hit_reg;
    logic [NODE_W-1:0]  nd_reg  [4];
    logic [LAYER_W-1:0] lay_reg [4];
    logic [CORE_W-1:0]  cor_reg [4];
    logic [CNT_W-1:0]   br_reg  [4];
    logic [CNT_W-1:0]   rd_reg  [4];
    logic               mm_reg  [4];

    mem_req_t   req;
    mem_rsp_t   rsp;
    onion_in_t  uin;
    onion_out_t uout;

    logic [1:0]        ki;
    logic [1:0]        cur_i;
    logic [1:0]        new_i;
    logic [NODE_W-1:0] pa;
    logic [NODE_W-1:0] pb;
    logic              load_out;
    out_item_t         out_next;

    ope_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    ope_onion_unit u_unit (
        .req (uin),
        .rsp (uout)
    );

    assign ki    = k_reg[1:0];
    assign cur_i = {ki[1], ~ki[0]};
    assign new_i = {~ki[1], ki[0] ^ item_reg.cross_req};
    assign pa    = nd_reg[{1'b1, item_reg.cross_req}];
    assign pb    = nd_reg[{1'b1, ~item_reg.cross_req}];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign load_out      = (state_reg == ST_RESP) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result fields
    always_comb
    begin
        out_next        = '0;
        out_next.status = status_reg;
        unique case (func_reg)
            FN_EDGE:
            begin
                out_next.new_first_a = nd_reg[0];
                out_next.new_first_b = nd_reg[1];
            end
            FN_SWAP:
            begin
                if (status_reg == STAT_OK)
                begin
                    out_next.new_first_a  = nd_reg[0];
                    out_next.new_first_b  = pa;
                    out_next.new_second_a = nd_reg[1];
                    out_next.new_second_b = pb;
                end
                else
                begin
                    out_next.new_first_a  = nd_reg[0];
                    out_next.new_first_b  = nd_reg[1];
                    out_next.new_second_a = nd_reg[2];
                    out_next.new_second_b = nd_reg[3];
                end
            end
            default:
            begin
                out_next.status = status_reg;
            end
        endcase
    end

    // sequencer: next state and store requests
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        req            = '0;
        uin            = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.adj_clr    = 1'b1;
                req.adj_row    = clr_reg;
                req.cnt_we     = 1'b1;
                req.cnt_addr   = clr_reg;
                req.minl_we    = 1'b1;
                req.minl_addr  = CORE_W'(clr_reg);
                req.minl_wdata = '1;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == NODE_W'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (func_t'(s_axis_tuser))
                        FN_NODE: state_next = ST_NODE_WR;
                        FN_EDGE: state_next = ST_EDGE_RD;
                        FN_SWAP: state_next = ST_SW_RD1;
                        FN_NOP:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_NODE_WR:
            begin
                req.node_we          = 1'b1;
                req.node_addr        = item_reg.node;
                req.node_wdata.layer = item_reg.layer;
                req.node_wdata.core  = item_reg.core;
                req.minl_addr        = item_reg.core;
                state_next           = ST_NODE_MIN;
            end
            ST_NODE_MIN:
            begin
                req.minl_addr  = item_reg.core;
                req.minl_wdata = item_reg.layer;
                req.minl_we    = (item_reg.layer < rsp.minl_rdata);
                state_next     = ST_RESP;
            end
            ST_EDGE_RD:
            begin
                req.edge_we      = 1'b1;
                req.edge_addr    = item_reg.edge_index;
                req.edge_wdata.a = nd_reg[0];
                req.edge_wdata.b = nd_reg[1];
                req.adj_row      = nd_reg[0];
                req.adj_col      = nd_reg[1];
                req.node_addr    = nd_reg[0];
                state_next       = ST_EDGE_CAP;
            end
            ST_EDGE_CAP:
            begin
                req.node_addr = nd_reg[1];
                req.cnt_addr  = nd_reg[0];
                state_next    = ST_EDGE_CNT;
            end
            ST_EDGE_CNT:
            begin
                state_next = hit_reg ? ST_RESP : ST_EDGE_WA;
            end
            ST_EDGE_WA:
            begin
                uin.mode_cnt     = 1'b1;
                uin.l            = lay_reg[0];
                uin.ln           = lay_reg[1];
                uin.br           = br_reg[0];
                uin.rd           = rd_reg[0];
                req.cnt_we       = 1'b1;
                req.cnt_addr     = nd_reg[0];
                req.cnt_wdata.br = uout.br_next;
                req.cnt_wdata.rd = uout.rd_next;
                req.adj_we       = 1'b1;
                req.adj_row      = nd_reg[0];
                req.adj_col      = nd_reg[1];
                req.adj_bit      = 1'b1;
                state_next       = ST_EDGE_RB;
            end
            ST_EDGE_RB:
            begin
                req.cnt_addr = nd_reg[1];
                req.adj_we   = 1'b1;
                req.adj_row  = nd_reg[1];
                req.adj_col  = nd_reg[0];
                req.adj_bit  = 1'b1;
                // a self-loop counts once
                state_next   = (nd_reg[0] == nd_reg[1]) ? ST_RESP : ST_EDGE_WB;
            end
            ST_EDGE_WB:
            begin
                uin.mode_cnt     = 1'b1;
                uin.l            = lay_reg[1];
                uin.ln           = lay_reg[0];
                uin.br           = rsp.cnt_rdata.br;
                uin.rd           = rsp.cnt_rdata.rd;
                req.cnt_we       = 1'b1;
                req.cnt_addr     = nd_reg[1];
                req.cnt_wdata.br = uout.br_next;
                req.cnt_wdata.rd = uout.rd_next;
                state_next       = ST_RESP;
            end
            ST_SW_RD1:
            begin
                req.edge_addr = item_reg.edge_index;
                state_next    = ST_SW_RD2;
            end
            ST_SW_RD2:
            begin
                req.edge_addr = item_reg.second_edge_index;
                state_next    = ST_SW_PAIR;
            end
            ST_SW_PAIR:
            begin
                state_next = ST_SW_SEL;
            end
            ST_SW_SEL:
            begin
                req.adj_row = nd_reg[0];
                req.adj_col = pa;
                if ((item_reg.edge_index == item_reg.second_edge_index)
                    || (nd_reg[0] == pa) || (nd_reg[1] == pb))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SW_ADJ1;
                end
            end
            ST_SW_ADJ1:
            begin
                req.adj_row = nd_reg[1];
                req.adj_col = pb;
                state_next  = ST_SW_ADJ2;
            end
            ST_SW_ADJ2:
            begin
                k_next     = '0;
                state_next = (hit_reg || rsp.adj_bit) ? ST_RESP : ST_SW_NRD;
            end
            ST_SW_NRD:
            begin
                req.node_addr = nd_reg[ki];
                req.cnt_addr  = nd_reg[ki];
                state_next    = ST_SW_NCAP;
            end
            ST_SW_NCAP:
            begin
                req.minl_addr = rsp.node_rdata.core;
                state_next    = ST_SW_MCAP;
            end
            ST_SW_MCAP:
            begin
                if (ki == 2'd3)
                begin
                    k_next     = '0;
                    state_next = ST_SW_CHECK;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_SW_NRD;
                end
            end
            ST_SW_CHECK:
            begin
                uin.l         = lay_reg[ki];
                uin.lc        = lay_reg[cur_i];
                uin.ln        = lay_reg[new_i];
                uin.core      = cor_reg[ki];
                uin.br        = br_reg[ki];
                uin.rd        = rd_reg[ki];
                uin.min_match = mm_reg[ki];
                if (uout.changed)
                begin
                    state_next = ST_RESP;
                end
                else if (ki == 2'd3)
                begin
                    k_next     = '0;
                    state_next = ST_SW_URD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_SW_URD:
            begin
                req.cnt_addr = nd_reg[ki];
                state_next   = ST_SW_UWR;
            end
            ST_SW_UWR:
            begin
                // re-read per node so that a node named twice takes both deltas
                uin.l            = lay_reg[ki];
                uin.lc           = lay_reg[cur_i];
                uin.ln           = lay_reg[new_i];
                uin.br           = rsp.cnt_rdata.br;
                uin.rd           = rsp.cnt_rdata.rd;
                req.cnt_we       = 1'b1;
                req.cnt_addr     = nd_reg[ki];
                req.cnt_wdata.br = uout.br_next;
                req.cnt_wdata.rd = uout.rd_next;
                if (ki == 2'd3)
                begin
                    k_next     = '0;
                    state_next = ST_SW_WRITE;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_SW_URD;
                end
            end
            ST_SW_WRITE:
            begin
                req.adj_we = 1'b1;
                unique case (k_reg)
                    3'd0:
                    begin
                        req.adj_row = nd_reg[0];
                        req.adj_col = nd_reg[1];
                    end
                    3'd1:
                    begin
                        req.adj_row = nd_reg[1];
                        req.adj_col = nd_reg[0];
                    end
                    3'd2:
                    begin
                        req.adj_row = nd_reg[2];
                        req.adj_col = nd_reg[3];
                    end
                    3'd3:
                    begin
                        req.adj_row = nd_reg[3];
                        req.adj_col = nd_reg[2];
                    end
                    3'd4:
                    begin
                        req.adj_row = nd_reg[0];
                        req.adj_col = pa;
                        req.adj_bit = 1'b1;
                    end
                    3'd5:
                    begin
                        req.adj_row = pa;
                        req.adj_col = nd_reg[0];
                        req.adj_bit = 1'b1;
                    end
                    3'd6:
                    begin
                        req.adj_row = nd_reg[1];
                        req.adj_col = pb;
                        req.adj_bit = 1'b1;
                    end
                    3'd7:
                    begin
                        req.adj_row = pb;
                        req.adj_col = nd_reg[1];
                        req.adj_bit = 1'b1;
                    end
                endcase
                if (k_reg == 3'd0)
                begin
                    req.edge_we      = 1'b1;
                    req.edge_addr    = item_reg.edge_index;
                    req.edge_wdata.a = nd_reg[0];
                    req.edge_wdata.b = pa;
                end
                else if (k_reg == 3'd1)
                begin
                    req.edge_we      = 1'b1;
                    req.edge_addr    = item_reg.second_edge_index;
                    req.edge_wdata.a = nd_reg[1];
                    req.edge_wdata.b = pb;
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    item_reg   <= in_item_t'(s_axis_tdata);
                    func_reg   <= func_t'(s_axis_tuser);
                    status_reg <= STAT_OK;
                    nd_reg[0]  <= s_axis_tdata[42:35];
                    nd_reg[1]  <= s_axis_tdata[50:43];
                end
            end
            ST_EDGE_CAP:
            begin
                hit_reg    <= rsp.adj_bit;
                lay_reg[0] <= rsp.node_rdata.layer;
            end
            ST_EDGE_CNT:
            begin
                lay_reg[1] <= rsp.node_rdata.layer;
                br_reg[0]  <= rsp.cnt_rdata.br;
                rd_reg[0]  <= rsp.cnt_rdata.rd;
            end
            ST_SW_RD2:
            begin
                nd_reg[0] <= rsp.edge_rdata.a;
                nd_reg[1] <= rsp.edge_rdata.b;
            end
            ST_SW_PAIR:
            begin
                nd_reg[2] <= rsp.edge_rdata.a;
                nd_reg[3] <= rsp.edge_rdata.b;
            end
            ST_SW_ADJ1:
            begin
                hit_reg <= rsp.adj_bit;
            end
            ST_SW_ADJ2:
            begin
                if (hit_reg || rsp.adj_bit)
                begin
                    status_reg <= STAT_EXISTS;
                end
            end
            ST_SW_NCAP:
            begin
                lay_reg[ki] <= rsp.node_rdata.layer;
                cor_reg[ki] <= rsp.node_rdata.core;
                br_reg[ki]  <= rsp.cnt_rdata.br;
                rd_reg[ki]  <= rsp.cnt_rdata.rd;
            end
            ST_SW_MCAP:
            begin
                mm_reg[ki] <= (rsp.minl_rdata == lay_reg[ki]);
            end
            ST_SW_CHECK:
            begin
                if (uout.changed)
                begin
                    status_reg <= STAT_ONION;
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    out_reg <= out_next;
                end
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase

        // same edge and self-loop verdicts, decided on the captured endpoints
        if (state_reg == ST_SW_SEL)
        begin
            if (item_reg.edge_index == item_reg.second_edge_index)
            begin
                status_reg <= STAT_SAME;
            end
            else if ((nd_reg[0] == pa) || (nd_reg[1] == pb))
            begin
                status_reg <= STAT_SELF_LOOP;
            end
        end
    end

    // The swap endpoints are captured in RD2 and PAIR; pa and pb must come
    // from the edge captured in PAIR, so SEL evaluates after that capture.
    `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted on consecutive cycles")
    `ASSERT_NEXT(a_hold_waiting_result, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "waiting result lost or altered")
    `ASSERT_IMPL(a_check_index, state_reg == ST_SW_CHECK || state_reg == ST_SW_URD,
        k_reg < 3'd4, "node index out of range during swap test")
    `ASSERT_IMPL(a_no_ready_in_clear, state_reg == ST_CLEAR, !s_axis_tready && !m_axis_tvalid,
        "handshake active during clearing pass")

endmodule
